[design/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Constants, round table and helper functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned Rounds     = 64;
	localparam int unsigned LenPos     = 56;
	localparam logic [7:0]  PadByte    = 8'h80;

	typedef logic [31:0] word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_byte;   // write input byte at fill position
		logic pad_byte;    // write padding/length byte at pad position
		logic [7:0] pad_value;
		logic [5:0] pad_pos;
		logic start_block; // load working vars, clear round counter
		logic round;       // run one round
		logic finish_block;// add working vars into chain
		logic restart;     // reset chain, fill, length
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0]  fill;
		logic        last_round;
		logic [63:0] msg_bits;
	} stat_t;

	function automatic word_t k_const(input logic [5:0] i);
		word_t k;
		unique case (i)
			6'd0: k=32'h428a2f98; 6'd1: k=32'h71374491; 6'd2: k=32'hb5c0fbcf;
			6'd3: k=32'he9b5dba5; 6'd4: k=32'h3956c25b; 6'd5: k=32'h59f111f1;
			6'd6: k=32'h923f82a4; 6'd7: k=32'hab1c5ed5; 6'd8: k=32'hd807aa98;
			6'd9: k=32'h12835b01; 6'd10: k=32'h243185be; 6'd11: k=32'h550c7dc3;
			6'd12: k=32'h72be5d74; 6'd13: k=32'h80deb1fe; 6'd14: k=32'h9bdc06a7;
			6'd15: k=32'hc19bf174; 6'd16: k=32'he49b69c1; 6'd17: k=32'hefbe4786;
			6'd18: k=32'h0fc19dc6; 6'd19: k=32'h240ca1cc; 6'd20: k=32'h2de92c6f;
			6'd21: k=32'h4a7484aa; 6'd22: k=32'h5cb0a9dc; 6'd23: k=32'h76f988da;
			6'd24: k=32'h983e5152; 6'd25: k=32'ha831c66d; 6'd26: k=32'hb00327c8;
			6'd27: k=32'hbf597fc7; 6'd28: k=32'hc6e00bf3; 6'd29: k=32'hd5a79147;
			6'd30: k=32'h06ca6351; 6'd31: k=32'h14292967; 6'd32: k=32'h27b70a85;
			6'd33: k=32'h2e1b2138; 6'd34: k=32'h4d2c6dfc; 6'd35: k=32'h53380d13;
			6'd36: k=32'h650a7354; 6'd37: k=32'h766a0abb; 6'd38: k=32'h81c2c92e;
			6'd39: k=32'h92722c85; 6'd40: k=32'ha2bfe8a1; 6'd41: k=32'ha81a664b;
			6'd42: k=32'hc24b8b70; 6'd43: k=32'hc76c51a3; 6'd44: k=32'hd192e819;
			6'd45: k=32'hd6990624; 6'd46: k=32'hf40e3585; 6'd47: k=32'h106aa070;
			6'd48: k=32'h19a4c116; 6'd49: k=32'h1e376c08; 6'd50: k=32'h2748774c;
			6'd51: k=32'h34b0bcb5; 6'd52: k=32'h391c0cb3; 6'd53: k=32'h4ed8aa4a;
			6'd54: k=32'h5b9cca4f; 6'd55: k=32'h682e6ff3; 6'd56: k=32'h748f82ee;
			6'd57: k=32'h78a5636f; 6'd58: k=32'h84c87814; 6'd59: k=32'h8cc70208;
			6'd60: k=32'h90befffa; 6'd61: k=32'ha4506ceb; 6'd62: k=32'hbef9a3f7;
			6'd63: k=32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic word_t h_init(input logic [2:0] i);
		word_t h;
		unique case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
			default: h = '0;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

[design/sha256_dp.sv]
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block buffer, message schedule window, round logic, chain words.
// ----------------------------------------------------------------------------
module sha256_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256_pkg::cmd_t    cmd,
	input  logic [7:0]          data_byte,
	output sha256_pkg::stat_t   stat,
	output logic [255:0]        chain
);
	import sha256_pkg::*;

	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	word_t       h_q [8];
	word_t       v_q [8];
	// Sixteen big-endian words: block buffer while bytes arrive, then the
	// schedule window (w_q[0] is the word of the current round).
	word_t       w_q [16];
	logic [5:0]  rnd_q;

	word_t w_cur, w_new, t1, t2, s0, s1, e, a;

	always_comb begin
		w_cur = w_q[0];
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + k_const(rnd_q) + w_cur;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end else if (cmd.load_byte) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte;
		end else if (cmd.pad_byte) begin
			w_q[cmd.pad_pos[5:2]][{~cmd.pad_pos[1:0], 3'b000} +: 8] <= cmd.pad_value;
		end
		if (cmd.start_block) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= h_init(3'(i));
		end else begin
			if (cmd.restart) begin
				fill_q <= '0;
				bits_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= h_init(3'(i));
			end else begin
				if (cmd.load_byte) begin
					fill_q <= fill_q + 6'd1;
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.finish_block) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.start_block)
				rnd_q <= '0;
			else if (cmd.round)
				rnd_q <= rnd_q + 6'd1;
		end
	end

	assign stat.fill       = fill_q;
	assign stat.last_round = (rnd_q == 6'(Rounds - 1));
	assign stat.msg_bits   = bits_q;
	assign chain = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule

[design/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// sha256_ctrl
// Controller: input handshake, padding sequence, compression sequencing.
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               has_byte,
	input  logic               end_of_message,
	input  logic               out_ready,
	output logic               out_valid,
	input  sha256_pkg::stat_t  stat,
	output sha256_pkg::cmd_t   cmd
);
	import sha256_pkg::*;

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StComp  = 3'd1; // rounds running
	localparam logic [2:0] StFin   = 3'd2; // add into chain
	localparam logic [2:0] StPad   = 3'd3; // write one padding byte per cycle
	localparam logic [2:0] StOut   = 3'd4;
	localparam logic [2:0] StStart = 3'd5;

	logic [2:0] state_q;
	logic       pending_q;  // padding still to do after this block
	logic       mark_q;     // 0x80 already written
	logic       lenblk_q;   // current padding block carries the length
	logic [5:0] pos_q;
	logic [5:0] first_pos;
	logic       acc;

	assign in_ready  = (state_q == StIdle);
	assign out_valid = (state_q == StOut);
	assign acc       = in_valid && in_ready;
	assign first_pos = stat.fill + {5'd0, has_byte};

	always_comb begin
		cmd = '0;
		cmd.load_byte   = acc && has_byte;
		cmd.pad_byte    = (state_q == StPad);
		cmd.pad_pos     = pos_q;
		cmd.start_block = (state_q == StStart);
		cmd.round       = (state_q == StComp);
		cmd.finish_block= (state_q == StFin);
		cmd.restart     = (state_q == StOut) && out_ready;
		if (!mark_q)
			cmd.pad_value = PadByte;
		else if (lenblk_q && pos_q >= 6'(LenPos))
			cmd.pad_value = stat.msg_bits[{~pos_q[2:0], 3'b000} +: 8];
		else
			cmd.pad_value = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			pending_q <= 1'b0;
			mark_q    <= 1'b0;
			lenblk_q  <= 1'b0;
			pos_q     <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (acc) begin
						pending_q <= end_of_message;
						mark_q    <= 1'b0;
						pos_q     <= first_pos;
						if (has_byte && stat.fill == 6'd63) begin
							state_q  <= StStart;
							lenblk_q <= 1'b0;
						end else if (end_of_message) begin
							state_q  <= StPad;
							lenblk_q <= (first_pos < 6'(LenPos));
						end
					end
				end
				StStart: state_q <= StComp;
				StComp: if (stat.last_round) state_q <= StFin;
				StFin: begin
					if (!pending_q)
						state_q <= StIdle;
					else if (lenblk_q)
						state_q <= StOut;
					else begin
						// length goes into a fresh block
						state_q  <= StPad;
						pos_q    <= 6'd0;
						lenblk_q <= 1'b1;
					end
				end
				StPad: begin
					mark_q <= 1'b1;
					pos_q  <= pos_q + 6'd1;
					if (pos_q == 6'd63)
						state_q <= StStart;
				end
				StOut: if (out_ready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> !cmd.load_byte)
		else $error("byte written during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StComp && stat.last_round) |=> state_q == StFin)
		else $error("round count lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while digest waits");

endmodule

[design/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a byte stream, digest on end mark.
// ----------------------------------------------------------------------------
// One item is taken per idle cycle; a byte that completes a 64-byte block
// holds input while one round unit runs 64 rounds and folds the result into
// the chain. An end mark writes the padding one byte per cycle (up to 64
// bytes per padding block) and runs one or two more compressions, then
// presents the digest until taken. Sustained throughput is set by the single
// shared round unit and the byte-wide buffer write port.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word0,
	output logic [63:0] digest_word1,
	output logic [63:0] digest_word2,
	output logic [63:0] digest_word3
);
	import sha256_pkg::*;

	cmd_t         cmd;
	stat_t        stat;
	logic [255:0] chain;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .has_byte, .end_of_message,
		.out_ready, .out_valid, .stat, .cmd
	);

	sha256_dp u_dp (
		.clk, .arst_n, .cmd, .data_byte, .stat, .chain
	);

	// Chain words sit in order, word 0 highest.
	assign digest_word0 = chain[255:192];
	assign digest_word1 = chain[191:128];
	assign digest_word2 = chain[127:64];
	assign digest_word3 = chain[63:0];

endmodule

[dv/sha256_digest_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the stream hasher, computes the SHA-256 digest of
// each message independently and compares every digest field by field.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] digest_word0,
	input  logic [63:0] digest_word1,
	input  logic [63:0] digest_word2,
	input  logic [63:0] digest_word3,
	output int          fail_count,
	output int          digests_pending
);

	typedef struct {
		logic [63:0] w[4];
	} digest_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

	logic [31:0] chain[8];
	logic [7:0]  blk[64];
	int unsigned fill;
	logic [63:0] bit_len;
	digest_t     digest_q[$];

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, a, e;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2],17) ^ ror(w[i-2],19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15],7) ^ ror(w[i-15],18) ^ (w[i-15] >> 3)) + w[i-16];
		v = chain;
		for (int i = 0; i < 64; i++) begin
			a = v[0];
			e = v[4];
			t1 = v[7] + (ror(e,6) ^ ror(e,11) ^ ror(e,25)) + ((e & v[5]) ^ (~e & v[6]))
				+ K_TAB[i] + w[i];
			t2 = (ror(a,2) ^ ror(a,13) ^ ror(a,22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic void restart_hash();
		chain = IV_TAB;
		fill = 0;
		bit_len = '0;
	endfunction

	// Advance the hash state by one input transaction; queue a digest on end mark.
	function automatic void absorb_item(logic [7:0] b, logic hb, logic eom);
		digest_t d;
		int unsigned pos;
		if (hb) begin
			blk[fill] = b;
			fill++;
			bit_len += 64'd8;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		end
		if (!eom)
			return;
		pos = fill;
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			blk[56+i] = bit_len[63-8*i -: 8];
		compress_block();
		for (int i = 0; i < 4; i++)
			d.w[i] = {chain[2*i], chain[2*i+1]};
		digest_q = {digest_q, d};
		restart_hash();
	endfunction

	always @(posedge clk) begin
		digest_t exp_d;
		logic [63:0] got[4];
		if (!arst_n) begin
			restart_hash();
			digest_q.delete();
			fail_count = 0;
		end else begin
			if (in_valid && in_ready)
				absorb_item(data_byte, has_byte, end_of_message);
			if (out_valid && out_ready) begin
				got = '{digest_word0, digest_word1, digest_word2, digest_word3};
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected digest %h", $realtime, got[0]);
				end else begin
					exp_d = digest_q.pop_front();
					for (int i = 0; i < 4; i++)
						if (got[i] !== exp_d.w[i]) begin
							fail_count++;
							if (fail_count <= 10)
								$display("%0t: digest_word%0d exp %h got %h", $realtime, i,
									exp_d.w[i], got[i]);
						end
				end
			end
		end
		digests_pending = digest_q.size();
	end

endmodule

[dv/tb_sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Drives byte-stream messages of random and edge-case lengths into the
// hasher with random gaps and back-pressure; a checker judges each digest.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] digest_word0, digest_word1, digest_word2, digest_word3;
	int          fail_count;
	int          digests_pending;
	bit          hold_req;   // long receiver stall request
	int          idle_cycles;
	int          n_sent;

	sha256_stream_hasher i_dut (.*);

	sha256_digest_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Half the time no gap, otherwise mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Offer one transaction at the falling edge and hold it until accepted.
	// Valid stays high on return so the next item can follow with no gap.
	task automatic send_item(logic [7:0] b, logic hb, logic eom, bit gaps);
		int g;
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		has_byte       <= hb;
		end_of_message <= eom;
		n_sent++;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Send a full message of the given length with random bytes.
	task automatic send_message(int len, bit gaps, bit noise);
		bit ended;
		ended = 1'b0;
		for (int i = 0; i < len; i++) begin
			// scatter empty items inside the message; they must change nothing
			if (noise && $urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0, gaps);
			if (i == len - 1 && $urandom_range(0, 1)) begin
				send_item(8'($urandom), 1'b1, 1'b1, gaps);
				ended = 1'b1;
			end else
				send_item(8'($urandom), 1'b1, 1'b0, gaps);
		end
		if (!ended)
			send_item(8'($urandom), 1'b0, 1'b1, gaps);
	endtask

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		int g;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
			end else begin
				g = pick_gap();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// Watchdog: abort when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int len;
		in_valid       = 1'b0;
		data_byte      = 8'h00;
		has_byte       = 1'b0;
		end_of_message = 1'b0;
		hold_req       = 1'b0;
		n_sent         = 0;
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, noise item, byte extremes, a three-byte message.
		send_item(8'h00, 1'b0, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b1, 1'b0);
		send_item(8'h61, 1'b1, 1'b0, 1'b0);
		send_item(8'h62, 1'b1, 1'b0, 1'b0);
		send_item(8'h63, 1'b1, 1'b1, 1'b0);

		// Lengths around the padding split and the block edge.
		for (int k = 0; k < 7; k++) begin
			len = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : (k == 3) ? 64 :
				(k == 4) ? 119 : (k == 5) ? 120 : 128;
			send_message(len, 1'b1, 1'b0);
		end

		// Back-pressure: stall the receiver while short messages keep coming.
		hold_req = 1'b1;
		for (int k = 0; k < 6; k++)
			send_message($urandom_range(0, 3), 1'b0, 1'b0);

		// Random messages, mostly short, a few spanning several blocks.
		while (n_sent < 1450) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 40);
			send_message(len, 1'b1, 1'b1);
		end
		in_valid <= 1'b0;

		while (digests_pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
